/* hw/rtl/jsmc_pkg.sv */
`default_nettype none
package jsmc_pkg;

  localparam int unsigned DefMaxDepth  = 32;
  localparam logic [15:0] DefMaxLength = 16'd16384;
  localparam logic [7:0]  DefKeyLimit  = 8'd96;

  localparam logic [0:0] RegMaxLength = 1'd0;
  localparam logic [0:0] RegKeyLimit  = 1'd1;

  localparam logic [2:0] StatOk        = 3'd0;
  localparam logic [2:0] StatMalformed = 3'd1;
  localparam logic [2:0] StatTooLarge  = 3'd2;
  localparam logic [2:0] StatTooDeep   = 3'd4;

  localparam logic [4:0] StTop    = 5'd0;
  localparam logic [4:0] StOpenObj = 5'd1;
  localparam logic [4:0] StOpenArr = 5'd2;
  localparam logic [4:0] StKey    = 5'd3;
  localparam logic [4:0] StValue  = 5'd4;
  localparam logic [4:0] StColon  = 5'd5;
  localparam logic [4:0] StAfter  = 5'd6;
  localparam logic [4:0] StDone   = 5'd7;
  localparam logic [4:0] StKstr   = 5'd8;
  localparam logic [4:0] StKesc   = 5'd9;
  localparam logic [4:0] StVstr   = 5'd10;
  localparam logic [4:0] StVesc   = 5'd11;
  localparam logic [4:0] StLitT   = 5'd12;
  localparam logic [4:0] StLitF   = 5'd13;
  localparam logic [4:0] StLitN   = 5'd14;
  localparam logic [4:0] StNSign  = 5'd15;
  localparam logic [4:0] StNZero  = 5'd16;
  localparam logic [4:0] StNInt   = 5'd17;
  localparam logic [4:0] StNDot   = 5'd18;
  localparam logic [4:0] StNFrac  = 5'd19;
  localparam logic [4:0] StNE     = 5'd20;
  localparam logic [4:0] StNESign = 5'd21;
  localparam logic [4:0] StNExp   = 5'd22;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [14:0] member_count;
  } result_t;

  function automatic logic is_ws(input logic [7:0] ch);
    return ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= 8'h30 && ch <= 8'h39;
  endfunction

  function automatic logic is_escape(input logic [7:0] ch);
    return ch == 8'h22 || ch == 8'h5C || ch == 8'h2F || ch == 8'h62 ||
           ch == 8'h66 || ch == 8'h6E || ch == 8'h72 || ch == 8'h74;
  endfunction

  // expected literal character; position 0 unused
  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      2'd0: case (pos)
        3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e"; default: c = 8'h00;
      endcase
      2'd1: case (pos)
        3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s"; 3'd4: c = "e"; default: c = 8'h00;
      endcase
      2'd2: case (pos)
        3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l"; default: c = 8'h00;
      endcase
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] k);
    return (k == 2'd1) ? 3'd5 : 3'd4;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/json_syntax_member_counter_top.sv */
`default_nettype none
// streaming json syntax checker: one byte beat per cycle while in_stall is low, one
// result beat on the byte marked last. input beat registered, lexer and nesting
// bit stack updated in one pass, result held in an output register.
module json_syntax_member_counter_top #(
  parameter int unsigned MAX_DEPTH = jsmc_pkg::DefMaxDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [14:0]      member_count
);
  import jsmc_pkg::*;

  logic [15:0] max_length;
  logic [7:0]  key_limit;
  logic        beat_valid;
  beat_t       beat;
  result_t     result;
  logic        result_valid;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= DefMaxLength;
      key_limit <= DefKeyLimit;
    end else if (cfg_write) begin
      case (cfg_index)
        RegMaxLength: max_length <= cfg_data;
        RegKeyLimit:  key_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // output slot frees when taken; input stalls only while a held result blocks
  assign out_free = !out_valid || !out_stall;
  assign in_stall = beat_valid && beat.last && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (!in_stall) begin
      beat_valid <= in_valid;
    end
    if (!in_stall && in_valid) beat <= '{data_byte: data_byte, last: last};
  end

  jsmc_lexer #(.MAX_DEPTH(MAX_DEPTH)) u_lexer (
    .clk(clk), .rst(rst),
    .beat_valid(beat_valid && !in_stall),
    .beat(beat),
    .max_length(max_length), .key_limit(key_limit),
    .result(result), .result_valid(result_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= result_valid;
    end
    if (out_free && result_valid) begin
      status <= result.status;
      member_count <= result.member_count;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && status == $past(status)))
    else $error("held result lost");
  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall)) else $error("spurious stall");
  a_ok_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != StatOk) |-> member_count == 15'd0)
    else $error("count on error");

endmodule
`default_nettype wire

/* hw/rtl/jsmc_lexer.sv */
`default_nettype none
module jsmc_lexer #(
  parameter int unsigned MAX_DEPTH = jsmc_pkg::DefMaxDepth
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              beat_valid,
  input  wire jsmc_pkg::beat_t   beat,
  input  wire logic [15:0]       max_length,
  input  wire logic [7:0]        key_limit,
  output jsmc_pkg::result_t      result,
  output logic                   result_valid
);
  import jsmc_pkg::*;

  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam logic [DW-1:0] DepthMax = DW'(MAX_DEPTH);

  logic [MAX_DEPTH-1:0] nest_stack, nest_stack_next;
  logic [DW-1:0]  nest_depth, nest_depth_next;
  logic [4:0]     lexer_state, lexer_state_next;
  logic [2:0]     sub_position, sub_position_next;
  logic [7:0]     key_length, key_length_next;
  logic [16:0]    byte_count, byte_count_next;
  logic [14:0]    top_count, top_count_next;
  logic [2:0]     first_error, first_error_next;

  logic [7:0] ch;
  logic       top_obj;
  logic [IW-1:0] top_idx;
  logic [IW-1:0] push_idx;
  logic [1:0]  lit_k;

  assign ch       = beat.data_byte;
  assign top_idx  = IW'(nest_depth - DW'(1));
  assign push_idx = IW'(nest_depth);
  assign top_obj  = (nest_depth != '0) && nest_stack[top_idx];
  assign lit_k    = 2'(lexer_state - StLitT);

  always_comb begin
    logic [2:0] err;
    logic vdone;
    logic after;
    logic open_c;
    logic open_obj;
    logic close_c;
    logic kadd;
    logic [2:0] st;
    err = 3'd0;
    vdone = 1'b0;
    after = 1'b0;
    open_c = 1'b0;
    open_obj = 1'b0;
    close_c = 1'b0;
    kadd = 1'b0;
    nest_stack_next = nest_stack;
    nest_depth_next = nest_depth;
    lexer_state_next = lexer_state;
    sub_position_next = sub_position;
    key_length_next = key_length;
    top_count_next = top_count;
    byte_count_next = (byte_count != 17'h1FFFF) ? byte_count + 17'd1 : byte_count;

    case (lexer_state)
      StTop: if (!is_ws(ch)) begin
        if (ch == "{") begin open_c = 1'b1; open_obj = 1'b1; end
        else if (ch == "[") open_c = 1'b1;
        else err = StatMalformed;
      end
      StOpenObj: if (!is_ws(ch)) begin
        if (ch == "}") close_c = 1'b1;
        else if (ch == "\"") begin key_length_next = 8'd0; lexer_state_next = StKstr; end
        else err = StatMalformed;
      end
      StKey: if (!is_ws(ch)) begin
        if (ch == "\"") begin key_length_next = 8'd0; lexer_state_next = StKstr; end
        else err = StatMalformed;
      end
      StOpenArr, StValue: if (!is_ws(ch)) begin
        if (lexer_state == StOpenArr && ch == "]") close_c = 1'b1;
        else if (ch == "{") begin open_c = 1'b1; open_obj = 1'b1; end
        else if (ch == "[") open_c = 1'b1;
        else if (ch == "\"") lexer_state_next = StVstr;
        else if (ch == "-") lexer_state_next = StNSign;
        else if (ch == "0") lexer_state_next = StNZero;
        else if (is_digit(ch)) lexer_state_next = StNInt;
        else if (ch == "t") begin lexer_state_next = StLitT; sub_position_next = 3'd1; end
        else if (ch == "f") begin lexer_state_next = StLitF; sub_position_next = 3'd1; end
        else if (ch == "n") begin lexer_state_next = StLitN; sub_position_next = 3'd1; end
        else err = StatMalformed;
      end
      StColon: if (!is_ws(ch)) begin
        if (ch == ":") lexer_state_next = StValue;
        else err = StatMalformed;
      end
      StAfter: after = 1'b1;
      StDone: if (!is_ws(ch)) err = StatMalformed;
      StKstr: begin
        if (ch == "\"") lexer_state_next = StColon;
        else if (ch == "\\") lexer_state_next = StKesc;
        else if (ch < 8'h20) err = StatMalformed;
        else kadd = 1'b1;
      end
      StKesc: if (is_escape(ch)) kadd = 1'b1; else err = StatMalformed;
      StVstr: begin
        if (ch == "\"") vdone = 1'b1;
        else if (ch == "\\") lexer_state_next = StVesc;
        else if (ch < 8'h20) err = StatMalformed;
      end
      StVesc: if (is_escape(ch)) lexer_state_next = StVstr; else err = StatMalformed;
      StLitT, StLitF, StLitN: begin
        if (sub_position < lit_len(lit_k) && ch == lit_char(lit_k, sub_position)) begin
          sub_position_next = sub_position + 3'd1;
          if (sub_position_next == lit_len(lit_k)) begin
            sub_position_next = 3'd0;
            vdone = 1'b1;
          end
        end else err = StatMalformed;
      end
      StNSign: begin
        if (ch == "0") lexer_state_next = StNZero;
        else if (is_digit(ch)) lexer_state_next = StNInt;
        else err = StatMalformed;
      end
      StNZero, StNInt: begin
        if (lexer_state == StNInt && is_digit(ch)) lexer_state_next = StNInt;
        else if (ch == ".") lexer_state_next = StNDot;
        else if (ch == "e" || ch == "E") lexer_state_next = StNE;
        else begin vdone = 1'b1; after = 1'b1; end
      end
      StNDot: if (is_digit(ch)) lexer_state_next = StNFrac; else err = StatMalformed;
      StNFrac: begin
        if (is_digit(ch)) lexer_state_next = StNFrac;
        else if (ch == "e" || ch == "E") lexer_state_next = StNE;
        else begin vdone = 1'b1; after = 1'b1; end
      end
      StNE: begin
        if (ch == "+" || ch == "-") lexer_state_next = StNESign;
        else if (is_digit(ch)) lexer_state_next = StNExp;
        else err = StatMalformed;
      end
      StNESign: if (is_digit(ch)) lexer_state_next = StNExp; else err = StatMalformed;
      StNExp: if (!is_digit(ch)) begin vdone = 1'b1; after = 1'b1; end
      default: err = StatMalformed;
    endcase

    // value completion (number end happens before the delimiter)
    if (vdone) begin
      lexer_state_next = StAfter;
      if (nest_depth == DW'(1) && top_count != 15'h7FFF) top_count_next = top_count + 15'd1;
    end
    if (after && !is_ws(ch)) begin
      if (ch == ",") lexer_state_next = top_obj ? StKey : StValue;
      else if (ch == "}" || ch == "]") close_c = 1'b1;
      else err = StatMalformed;
    end
    if (kadd) begin
      if ({1'b0, key_length} + 9'd1 >= {1'b0, key_limit}) err = StatTooLarge;
      else begin
        key_length_next = key_length + 8'd1;
        lexer_state_next = StKstr;
      end
    end
    if (open_c) begin
      if (nest_depth >= DepthMax) err = StatTooDeep;
      else begin
        nest_stack_next[push_idx] = open_obj;
        nest_depth_next = nest_depth + DW'(1);
        lexer_state_next = open_obj ? StOpenObj : StOpenArr;
      end
    end
    if (close_c) begin
      if (nest_depth == '0 || ch != (top_obj ? 8'h7D : 8'h5D)) err = StatMalformed;
      else begin
        nest_depth_next = nest_depth - DW'(1);
        if (nest_depth == DW'(1)) lexer_state_next = StDone;
        else begin
          lexer_state_next = StAfter;
          if (nest_depth == DW'(2) && top_count_next != 15'h7FFF)
            top_count_next = top_count_next + 15'd1;
        end
      end
    end

    first_error_next = first_error;
    if (first_error != 3'd0) begin
      nest_stack_next = nest_stack;
      nest_depth_next = nest_depth;
      lexer_state_next = lexer_state;
      sub_position_next = sub_position;
      key_length_next = key_length;
      top_count_next = top_count;
    end else if (err != 3'd0) begin
      first_error_next = err;
      nest_stack_next = nest_stack;
      nest_depth_next = nest_depth;
      lexer_state_next = lexer_state;
      sub_position_next = sub_position;
      key_length_next = key_length;
      top_count_next = top_count;
    end

    if (byte_count_next > {1'b0, max_length}) st = StatTooLarge;
    else if (first_error_next != 3'd0) st = first_error_next;
    else if (lexer_state_next != StDone) st = StatMalformed;
    else st = StatOk;
    result.status = st;
    result.member_count = (st == StatOk) ? top_count_next : 15'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (beat_valid && beat.last)) begin
      nest_stack <= '0;
      nest_depth <= '0;
      lexer_state <= StTop;
      sub_position <= 3'd0;
      key_length <= 8'd0;
      byte_count <= 17'd0;
      top_count <= 15'd0;
      first_error <= 3'd0;
    end else if (beat_valid) begin
      nest_stack <= nest_stack_next;
      nest_depth <= nest_depth_next;
      lexer_state <= lexer_state_next;
      sub_position <= sub_position_next;
      key_length <= key_length_next;
      byte_count <= byte_count_next;
      top_count <= top_count_next;
      first_error <= first_error_next;
    end
  end

  assign result_valid = beat_valid && beat.last;

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    nest_depth <= DepthMax) else $error("nesting depth overflow");
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (first_error != 3'd0 && !(beat_valid && beat.last)) |=> first_error == $past(first_error))
    else $error("first error changed");
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (beat_valid && beat.last) |=> (nest_depth == '0 && lexer_state == StTop))
    else $error("parse state not cleared");

endmodule
`default_nettype wire

/* bench/tb_json_syntax_member_counter_top.sv */
module tb_json_syntax_member_counter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import jsmc_pkg::*;

  localparam int Depth = DefMaxDepth;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        last;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [14:0] member_count;

  json_syntax_member_counter_top uut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .last(last), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .member_count(member_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // shadow of the checker state
  int unsigned max_len_reg = DefMaxLength;
  int unsigned key_lim_reg = DefKeyLimit;
  bit          nest_obj[Depth];
  int          nest_lvl;
  logic [4:0]  lex_st;
  int          lit_pos;
  int          key_len;
  int          doc_bytes;
  int          members;
  logic [2:0]  first_err;
  string       lit_words[3] = '{"true", "false", "null"};

  result_t     expected_results[$];
  int          errors;
  int          results_seen;
  bit          quiet;
  logic [7:0]  doc[$];

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic bit blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit simple_escape(input logic [7:0] c);
    return c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
           c == "n" || c == "r" || c == "t";
  endfunction

  task flag(input logic [2:0] code);
    if (first_err == StatOk) first_err = code;
  endtask

  task clear_doc();
    for (int i = 0; i < Depth; i++) nest_obj[i] = 1'b0;
    nest_lvl = 0;
    lex_st = StTop;
    lit_pos = 0;
    key_len = 0;
    doc_bytes = 0;
    members = 0;
    first_err = StatOk;
  endtask

  task value_closed();
    lex_st = StAfter;
    if (nest_lvl == 1 && members < 32767) members++;
  endtask

  task open_nest(input bit obj);
    if (nest_lvl >= Depth) begin
      flag(StatTooDeep);
    end else begin
      nest_obj[nest_lvl] = obj;
      nest_lvl++;
      lex_st = obj ? StOpenObj : StOpenArr;
    end
  endtask

  task close_nest(input logic [7:0] c);
    logic [7:0] want;
    if (nest_lvl == 0) begin
      flag(StatMalformed);
    end else begin
      want = nest_obj[nest_lvl-1] ? "}" : "]";
      if (c != want) begin
        flag(StatMalformed);
      end else begin
        nest_lvl--;
        if (nest_lvl == 0) lex_st = StDone;
        else value_closed();
      end
    end
  endtask

  task key_char();
    if (key_len + 1 >= key_lim_reg) begin
      flag(StatTooLarge);
    end else begin
      key_len++;
      lex_st = StKstr;
    end
  endtask

  task value_begin(input logic [7:0] c);
    if (c == "{") open_nest(1'b1);
    else if (c == "[") open_nest(1'b0);
    else if (c == "\"") lex_st = StVstr;
    else if (c == "-") lex_st = StNSign;
    else if (c == "0") lex_st = StNZero;
    else if (numeral(c)) lex_st = StNInt;
    else if (c == "t") begin lex_st = StLitT; lit_pos = 1; end
    else if (c == "f") begin lex_st = StLitF; lit_pos = 1; end
    else if (c == "n") begin lex_st = StLitN; lit_pos = 1; end
    else flag(StatMalformed);
  endtask

  task after_val(input logic [7:0] c);
    if (!blank(c)) begin
      if (c == ",") lex_st = (nest_lvl > 0 && nest_obj[nest_lvl-1]) ? StKey : StValue;
      else if (c == "}" || c == "]") close_nest(c);
      else flag(StatMalformed);
    end
  endtask

  task number_end(input logic [7:0] c);
    value_closed();
    after_val(c);
  endtask

  task lex_byte(input logic [7:0] c);
    int k;
    case (lex_st)
      StTop: begin
        if (!blank(c)) begin
          if (c == "{") open_nest(1'b1);
          else if (c == "[") open_nest(1'b0);
          else flag(StatMalformed);
        end
      end
      StOpenObj: begin
        if (!blank(c)) begin
          if (c == "}") close_nest(c);
          else if (c == "\"") begin key_len = 0; lex_st = StKstr; end
          else flag(StatMalformed);
        end
      end
      StOpenArr: begin
        if (!blank(c)) begin
          if (c == "]") close_nest(c);
          else value_begin(c);
        end
      end
      StKey: begin
        if (!blank(c)) begin
          if (c == "\"") begin key_len = 0; lex_st = StKstr; end
          else flag(StatMalformed);
        end
      end
      StValue: if (!blank(c)) value_begin(c);
      StColon: begin
        if (!blank(c)) begin
          if (c == ":") lex_st = StValue;
          else flag(StatMalformed);
        end
      end
      StAfter: after_val(c);
      StDone: if (!blank(c)) flag(StatMalformed);
      StKstr: begin
        if (c == "\"") lex_st = StColon;
        else if (c == "\\") lex_st = StKesc;
        else if (c < 8'h20) flag(StatMalformed);
        else key_char();
      end
      StKesc: begin
        if (simple_escape(c)) key_char();
        else flag(StatMalformed);
      end
      StVstr: begin
        if (c == "\"") value_closed();
        else if (c == "\\") lex_st = StVesc;
        else if (c < 8'h20) flag(StatMalformed);
      end
      StVesc: begin
        if (simple_escape(c)) lex_st = StVstr;
        else flag(StatMalformed);
      end
      StLitT, StLitF, StLitN: begin
        k = lex_st - StLitT;
        if (lit_pos < lit_words[k].len() && c == lit_words[k][lit_pos]) begin
          lit_pos++;
          if (lit_pos == lit_words[k].len()) begin
            lit_pos = 0;
            value_closed();
          end
        end else begin
          flag(StatMalformed);
        end
      end
      StNSign: begin
        if (c == "0") lex_st = StNZero;
        else if (numeral(c)) lex_st = StNInt;
        else flag(StatMalformed);
      end
      StNZero, StNInt: begin
        if (!(lex_st == StNInt && numeral(c))) begin
          if (c == ".") lex_st = StNDot;
          else if (c == "e" || c == "E") lex_st = StNE;
          else number_end(c);
        end
      end
      StNDot: begin
        if (numeral(c)) lex_st = StNFrac;
        else flag(StatMalformed);
      end
      StNFrac: begin
        if (!numeral(c)) begin
          if (c == "e" || c == "E") lex_st = StNE;
          else number_end(c);
        end
      end
      StNE: begin
        if (c == "+" || c == "-") lex_st = StNESign;
        else if (numeral(c)) lex_st = StNExp;
        else flag(StatMalformed);
      end
      StNESign: begin
        if (numeral(c)) lex_st = StNExp;
        else flag(StatMalformed);
      end
      StNExp: if (!numeral(c)) number_end(c);
      default: flag(StatMalformed);
    endcase
  endtask

  task check_byte(input logic [7:0] c, input logic fin, output bit done, output result_t r);
    if (doc_bytes < 131071) doc_bytes++;
    if (first_err == StatOk) lex_byte(c);
    done = fin;
    r = '0;
    if (fin) begin
      if (doc_bytes > max_len_reg) r.status = StatTooLarge;
      else if (first_err != StatOk) r.status = first_err;
      else if (lex_st != StDone) r.status = StatMalformed;
      else r.status = StatOk;
      r.member_count = (r.status == StatOk) ? members[14:0] : 15'd0;
      clear_doc();
    end
  endtask

  // sends one byte beat; typed overrides the predicted result on the last beat
  task send_byte(input logic [7:0] c, input logic fin, input int typed_st, input int typed_cnt);
    bit ok;
    bit done;
    result_t r;
    if (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= c;
    last <= fin;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    check_byte(c, fin, done, r);
    if (done) begin
      if (typed_st >= 0) begin
        r.status = typed_st[2:0];
        r.member_count = typed_cnt[14:0];
      end
      expected_results.push_back(r);
    end
  endtask

  task send_doc(input int typed_st, input int typed_cnt);
    foreach (doc[i]) send_byte(doc[i], i == doc.size() - 1, typed_st, typed_cnt);
  endtask

  task drain();
    in_valid <= 1'b0;
    last <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task set_regs(input logic [15:0] len_v, input logic [7:0] key_v);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= RegMaxLength;
    cfg_data <= len_v;
    @(posedge clk);
    cfg_index <= RegKeyLimit;
    cfg_data <= {8'h00, key_v};
    @(posedge clk);
    cfg_write <= 1'b0;
    max_len_reg = len_v;
    key_lim_reg = key_v;
  endtask

  function automatic void put_ws();
    logic [7:0] pick[4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};
    if ($urandom_range(0, 3) == 0) doc.push_back(pick[$urandom_range(0, 3)]);
  endfunction

  function automatic void put_string(input bit is_key);
    int n;
    logic [7:0] esc[8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};
    n = (is_key && $urandom_range(0, 29) == 0) ? $urandom_range(250, 258) : $urandom_range(0, 6);
    doc.push_back("\"");
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: begin doc.push_back("\\"); doc.push_back(esc[$urandom_range(0, 7)]); end
        1: doc.push_back($urandom_range(8'h80, 8'hFF));
        default: doc.push_back($urandom_range("a", "z"));
      endcase
    end
    doc.push_back("\"");
  endfunction

  function automatic void put_digits();
    repeat ($urandom_range(1, 3)) doc.push_back($urandom_range("0", "9"));
  endfunction

  function automatic void put_value(input int lvl);
    int r;
    int n;
    string w;
    r = $urandom_range(0, 9);
    if (lvl < 3 && r < 3) begin
      n = $urandom_range(0, 3);
      if (r == 0) begin
        doc.push_back("{");
        for (int i = 0; i < n; i++) begin
          if (i > 0) doc.push_back(",");
          put_ws(); put_string(1'b1); put_ws(); doc.push_back(":");
          put_ws(); put_value(lvl + 1); put_ws();
        end
        doc.push_back("}");
      end else begin
        doc.push_back("[");
        for (int i = 0; i < n; i++) begin
          if (i > 0) doc.push_back(",");
          put_ws(); put_value(lvl + 1); put_ws();
        end
        doc.push_back("]");
      end
    end else if (r < 5) begin
      put_string(1'b0);
    end else if (r < 8) begin
      if ($urandom_range(0, 2) == 0) doc.push_back("-");
      if ($urandom_range(0, 2) == 0) doc.push_back("0");
      else begin doc.push_back($urandom_range("1", "9")); put_digits(); end
      if ($urandom_range(0, 2) == 0) begin doc.push_back("."); put_digits(); end
      if ($urandom_range(0, 2) == 0) begin
        doc.push_back($urandom_range(0, 1) ? "e" : "E");
        case ($urandom_range(0, 2))
          0: doc.push_back("+");
          1: doc.push_back("-");
          default: ;
        endcase
        put_digits();
      end
    end else begin
      w = lit_words[$urandom_range(0, 2)];
      for (int i = 0; i < w.len(); i++) doc.push_back(w[i]);
    end
  endfunction

  function automatic void make_doc();
    int r;
    int d;
    doc.delete();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 8)) doc.push_back($urandom_range(0, 255));
    end else if (r < 12) begin
      d = $urandom_range(Depth - 2, Depth + 2);
      repeat (d) doc.push_back("[");
      repeat (d) doc.push_back("]");
    end else begin
      put_ws();
      put_value(0);
      while (doc[doc.size()-1] != "}" && doc[doc.size()-1] != "]") begin
        doc.delete();
        put_value(0);
      end
      put_ws();
      if (r < 24) doc[$urandom_range(0, doc.size() - 1)] = $urandom_range(0, 255);
      else if (r < 29 && doc.size() > 1) doc = doc[0:$urandom_range(0, doc.size() - 2)];
    end
  endfunction

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !quiet && $urandom_range(0, 99) < 20;
  end

  always @(negedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result status %0d count %0d", status, member_count));
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status)
          report($sformatf("status %0d, wanted %0d", status, want.status));
        if (member_count !== want.member_count)
          report($sformatf("member_count %0d, wanted %0d", member_count, want.member_count));
      end
    end
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    string rows[$];
    int    row_st[$];
    int    row_cnt[$];
    string s;
    int    sent;
    int    docs;
    int    quiet_end;
    logic [15:0] lens[4];
    logic [7:0]  keys[4];

    lens = '{16'd65535, 16'd1, 16'd12, 16'd16384};
    keys = '{8'd255, 8'd2, 8'd5, 8'd96};
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = RegMaxLength;
    cfg_data = '0;
    in_valid = 1'b0;
    data_byte = '0;
    last = 1'b0;
    quiet = 1'b0;
    errors = 0;
    results_seen = 0;
    clear_doc();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows = '{"{}", "[]", " [1,-0.5e+3,true,false,null] ", "{\"a\":1,\"b\":[2]}",
             "[\"\\u0041\"]", "[\"\\0\"]", "[\"a\001\"]", "{\"k\":tru}", "[1,]",
             "[01]", "{", "x", "[]x", "[nullx]", "[\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"]",
             "{\"\":0}", "[\t\n\r\013\014]", "", ""};
    row_st = '{0, 0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 4, -1};
    row_cnt = '{0, 0, 5, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0};
    s = "";
    repeat (Depth + 1) s = {s, "["};
    rows[17] = s;
    s = "";
    repeat (Depth) s = {s, "["};
    repeat (Depth) s = {s, "]"};
    rows[18] = s;
    sent = 0;
    foreach (rows[i]) begin
      doc.delete();
      for (int j = 0; j < rows[i].len(); j++) doc.push_back(rows[i][j]);
      sent += doc.size();
      send_doc(row_st[i], row_cnt[i]);
    end

    docs = 0;
    for (int p = 0; p < 4; p++) begin
      set_regs(lens[p], keys[p]);
      make_doc();
      sent += doc.size();
      send_doc(-1, 0);
      docs++;
    end
    quiet_end = sent + 60;
    while (sent < 450) begin
      if (docs % 3 == 0)
        set_regs($urandom_range(0, 1) ? $urandom_range(8, 40) : $urandom_range(1, 65535),
                 $urandom_range(2, 255));
      quiet = sent < quiet_end;
      make_doc();
      sent += doc.size();
      send_doc(-1, 0);
      docs++;
    end
    quiet = 1'b0;
    drain();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/jsmc_pkg.sv
hw/rtl/jsmc_lexer.sv
hw/rtl/json_syntax_member_counter_top.sv
bench/tb_json_syntax_member_counter_top.sv
